// ----- rtl/core/rmst_pkg.sv -----
// Shared constants and types for the range maximum segment tree.
// Used by the top level and by the tree store RAM instance sizing.
`default_nettype none

package rmst_pkg;

  localparam int MAX_LEAVES = 1024;
  localparam int VALUE_BITS = 31;
  localparam int LEAF_BITS  = $clog2(MAX_LEAVES);
  localparam int NODE_BITS  = LEAF_BITS + 1;
  localparam int NODE_COUNT = 2 * MAX_LEAVES;
  localparam int BOUND_BITS = NODE_BITS + 1;
  localparam int CFG_BITS   = 11;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_W_LEAF,
    ST_W_CLIMB,
    ST_Q_RUN,
    ST_Q_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/rmst_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module rmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [ADDR_BITS-1:0] raddr_a,
  output logic      [WIDTH-1:0]     rdata_a,
  input  wire logic [ADDR_BITS-1:0] raddr_b,
  output logic      [WIDTH-1:0]     rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ----- rtl/core/range_max_segment_tree.sv -----
// Range maximum segment tree, top level.
// Depends on rmst_pkg and the rmst_ram tree store.
`default_nettype none

// Bottom-up segment tree over leaf_count leaves (1..1024), kept in a
// 2048-word store with two read ports and one write port. After reset the
// block sweeps the whole store to zero, one word a cycle; in_ready stays
// low during the sweep, while leaf_count writes are taken at any time
// (write it only while the block is idle). A write item (opcode 0) sets
// one leaf and recomputes its ancestors: the block takes the item, stores
// the leaf, then writes each ancestor in turn up to the root, where a
// single max unit combines the running value with the sibling read the
// cycle before. A write past the last leaf is dropped in the accept cycle.
// A query item (opcode 1) climbs from both ends of index..range_end,
// reading up to two nodes per level; it takes the item, visits each level,
// merges the last reads, and loads the result register once it is free.
// Empty or out-of-range queries skip the climb and answer 0. A finished
// result waits in its output register, so writes can proceed while the
// result is still untaken; a second query waits for it.
module range_max_segment_tree (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           opcode,
  input  wire logic [rmst_pkg::LEAF_BITS-1:0]  index,
  input  wire logic [rmst_pkg::LEAF_BITS-1:0]  range_end,
  input  wire logic [rmst_pkg::VALUE_BITS-1:0] value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [rmst_pkg::VALUE_BITS-1:0] max_value,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rmst_pkg::CFG_BITS-1:0]   leaf_count
);

  import rmst_pkg::*;

  state_t                state, state_next;
  logic [NODE_BITS-1:0]  cur, cur_next;       // node being written
  logic [VALUE_BITS-1:0] acc, acc_next;       // running value or maximum
  logic [BOUND_BITS-1:0] lo, lo_next;         // half-open node range
  logic [BOUND_BITS-1:0] hi, hi_next;
  logic                  pend_lo, pend_lo_next;
  logic                  pend_hi, pend_hi_next;
  logic [NODE_BITS-1:0]  clr_addr, clr_addr_next;
  logic [CFG_BITS-1:0]   lc;
  logic                  out_valid_next;
  logic [VALUE_BITS-1:0] max_value_next;

  logic [NODE_BITS-1:0]  n_use;
  logic [NODE_BITS-1:0]  last;
  logic                  we;
  logic [NODE_BITS-1:0]  waddr, raddr_a, raddr_b;
  logic [VALUE_BITS-1:0] wdata, rdata_a, rdata_b;
  logic [VALUE_BITS-1:0] merge_a, merge_b;
  logic [BOUND_BITS-1:0] hi_dec;

  rmst_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (NODE_COUNT)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // Leaf count in use: zero acts as one, large values saturate.
  always_comb begin
    if (lc == '0) begin
      n_use = NODE_BITS'(1);
    end else if (lc > CFG_BITS'(MAX_LEAVES)) begin
      n_use = NODE_BITS'(MAX_LEAVES);
    end else begin
      n_use = lc[NODE_BITS-1:0];
    end
  end

  // Clamp the query end to the last leaf.
  always_comb begin
    if ({1'b0, range_end} >= n_use) begin
      last = n_use - NODE_BITS'(1);
    end else begin
      last = {1'b0, range_end};
    end
  end

  // Shared max unit: fold in the reads issued the cycle before.
  always_comb begin
    merge_a = acc;
    if (pend_lo && (rdata_a > acc)) begin
      merge_a = rdata_a;
    end
    merge_b = merge_a;
    if (pend_hi && (rdata_b > merge_a)) begin
      merge_b = rdata_b;
    end
  end

  assign hi_dec    = hi - BOUND_BITS'(1);
  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      lc        <= CFG_BITS'(MAX_LEAVES);
      out_valid <= 1'b0;
      pend_lo   <= 1'b0;
      pend_hi   <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      out_valid <= out_valid_next;
      pend_lo   <= pend_lo_next;
      pend_hi   <= pend_hi_next;
      if (cfg_valid && cfg_ready) begin
        lc <= leaf_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    acc       <= acc_next;
    lo        <= lo_next;
    hi        <= hi_next;
    max_value <= max_value_next;
  end

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    acc_next       = acc;
    lo_next        = lo;
    hi_next        = hi;
    pend_lo_next   = 1'b0;
    pend_hi_next   = 1'b0;
    clr_addr_next  = clr_addr;
    max_value_next = max_value;
    out_valid_next = out_valid && !out_ready;
    we             = 1'b0;
    waddr          = cur;
    wdata          = acc;
    raddr_a        = cur ^ NODE_BITS'(1);
    raddr_b        = hi_dec[NODE_BITS-1:0];

    case (state)
      ST_CLEAR: begin
        // Zero the store one word a cycle.
        we            = 1'b1;
        waddr         = clr_addr;
        wdata         = '0;
        clr_addr_next = clr_addr + NODE_BITS'(1);
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          if (opcode == OP_WRITE) begin
            // Drop writes beyond the last leaf.
            if ({1'b0, index} < n_use) begin
              cur_next   = n_use + {1'b0, index};
              acc_next   = value;
              state_next = ST_W_LEAF;
            end
          end else begin
            acc_next = '0;
            if (({1'b0, index} >= n_use) || ({1'b0, index} > last)) begin
              state_next = ST_Q_DONE;
            end else begin
              lo_next    = {1'b0, n_use} + {2'b0, index};
              hi_next    = {1'b0, n_use} + {1'b0, last} + BOUND_BITS'(1);
              state_next = ST_Q_RUN;
            end
          end
        end
      end

      ST_W_LEAF: begin
        // Store the leaf and fetch its sibling.
        we = 1'b1;
        if (cur == NODE_BITS'(1)) begin
          state_next = ST_IDLE;
        end else begin
          cur_next   = cur >> 1;
          state_next = ST_W_CLIMB;
        end
      end

      ST_W_CLIMB: begin
        // Parent = max(path value, sibling); fetch the parent's sibling.
        we    = 1'b1;
        wdata = merge_a;
        if (rdata_a > acc) begin
          wdata = rdata_a;
        end
        acc_next = wdata;
        if (cur == NODE_BITS'(1)) begin
          state_next = ST_IDLE;
        end else begin
          cur_next = cur >> 1;
        end
      end

      ST_Q_RUN: begin
        acc_next = merge_b;
        if (lo < hi) begin
          // Take the boundary node on each side whose bound is odd, then climb.
          raddr_a      = lo[NODE_BITS-1:0];
          raddr_b      = hi_dec[NODE_BITS-1:0];
          pend_lo_next = lo[0];
          pend_hi_next = hi[0];
          lo_next      = (lo + {{(BOUND_BITS-1){1'b0}}, lo[0]}) >> 1;
          hi_next      = hi >> 1;
        end else begin
          state_next = ST_Q_DONE;
        end
      end

      ST_Q_DONE: begin
        // Hold until the output register is free.
        if (!out_valid || out_ready) begin
          max_value_next = acc;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_range_max_segment_tree.sv -----
// Self-checking testbench for range_max_segment_tree: directed and random
// leaf writes and range-maximum queries under several leaf counts.
// Depends on rmst_pkg and the range_max_segment_tree RTL.

module tb_range_max_segment_tree;

  import rmst_pkg::*;

  // Cycles to let a write climb the tree after the last query result.
  localparam int SETTLE_CYCLES = 40;
  // Generous bound: clearing sweep plus every item at its slowest, many times.
  localparam int CYCLE_LIMIT   = 600000;
  localparam int IDLE_PERCENT  = 18;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic                  opcode     = OP_WRITE;
  logic [LEAF_BITS-1:0]  index      = '0;
  logic [LEAF_BITS-1:0]  range_end  = '0;
  logic [VALUE_BITS-1:0] value      = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic [VALUE_BITS-1:0] max_value;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_BITS-1:0]   leaf_count = '0;

  // Shadow copy of the tree store and the leaf count register.
  logic [VALUE_BITS-1:0] shadow_tree [0:NODE_COUNT-1];
  logic [CFG_BITS-1:0]   shadow_leaf_count;

  // Query answers still owed by the block, oldest first.
  logic [VALUE_BITS-1:0] pending_max [$];
  logic [VALUE_BITS-1:0] owed_max;

  int  error_count = 0;
  int  cycle_count = 0;
  bit  steady_mode = 1'b0;  // when set, neither side idles

  range_max_segment_tree i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .index     (index),
    .range_end (range_end),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .max_value (max_value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .leaf_count(leaf_count)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow tree
  // ---------------------------------------------------------------------

  // Leaf count the block actually uses: zero acts as one, large values clip.
  function automatic int unsigned leaves_in_use();
    if (shadow_leaf_count == 0) return 1;
    if (shadow_leaf_count > MAX_LEAVES) return MAX_LEAVES;
    return shadow_leaf_count;
  endfunction

  // Set one leaf and recompute every ancestor up to the root.
  function automatic void shadow_write_leaf(int unsigned leaf, logic [VALUE_BITS-1:0] v);
    int unsigned n;
    int unsigned node;
    n = leaves_in_use();
    if (leaf >= n) return;  // drop writes past the last leaf
    node = n + leaf;
    shadow_tree[node] = v;
    for (node = node >> 1; node != 0; node = node >> 1) begin
      shadow_tree[node] = (shadow_tree[2*node] > shadow_tree[2*node+1]) ?
                          shadow_tree[2*node] : shadow_tree[2*node+1];
    end
  endfunction

  // Climb from both ends of the inclusive range over half-open node bounds.
  function automatic logic [VALUE_BITS-1:0] shadow_range_max(int unsigned first,
                                                              int unsigned last);
    int unsigned           n;
    int unsigned           lo;
    int unsigned           hi;
    logic [VALUE_BITS-1:0] best;
    n = leaves_in_use();
    best = '0;
    if (first >= n) return '0;
    if (last >= n) last = n - 1;
    if (first > last) return '0;
    lo = n + first;
    hi = n + last + 1;
    while (lo < hi) begin
      if (lo[0]) begin
        if (shadow_tree[lo] > best) best = shadow_tree[lo];
        lo++;
      end
      if (hi[0]) begin
        hi--;
        if (shadow_tree[hi] > best) best = shadow_tree[hi];
      end
      lo = lo >> 1;
      hi = hi >> 1;
    end
    return best;
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [VALUE_BITS-1:0] got,
                                 logic [VALUE_BITS-1:0] want);
    $display("MISMATCH @%0d: %s: got %0d, expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // Compare each taken result with the oldest owed answer.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_max.size() == 0) begin
        report_mismatch("max_value with no query pending", max_value, '0);
      end else begin
        owed_max = pending_max.pop_front();
        if (max_value !== owed_max) report_mismatch("max_value", max_value, owed_max);
      end
    end
  end

  // Receiver: stall at random unless in a steady stretch.
  always @(posedge clk) begin
    out_ready <= steady_mode ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  // Offer one item, hold it until taken, then update the shadow tree.
  // Valid stays high on return so that back-to-back items need no gap.
  task automatic send_item(opcode_t op, logic [LEAF_BITS-1:0] first,
                           logic [LEAF_BITS-1:0] last, logic [VALUE_BITS-1:0] v);
    if (!steady_mode && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < IDLE_PERCENT) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    index     <= first;
    range_end <= last;
    value     <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_WRITE) shadow_write_leaf(first, v);
    else pending_max.insert(pending_max.size(), shadow_range_max(first, last));
  endtask

  // Drop valid, let every owed answer arrive, then let a trailing write settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_max.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the leaf count register, only with the block idle.
  task automatic set_leaf_count(logic [CFG_BITS-1:0] count);
    wait_idle();
    cfg_valid  <= 1'b1;
    leaf_count <= count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_leaf_count = count;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return {VALUE_BITS{1'b1}};
      2:       return VALUE_BITS'($urandom_range(0, 15));
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // One random item, mostly inside the leaves in use.
  task automatic send_random_item();
    int unsigned          n;
    logic [LEAF_BITS-1:0] first;
    logic [LEAF_BITS-1:0] last;
    int unsigned          span;
    n = leaves_in_use();
    if ($urandom_range(0, 99) < 88) first = LEAF_BITS'($urandom_range(0, n - 1));
    else first = LEAF_BITS'($urandom);
    case ($urandom_range(0, 9))
      0, 1:    last = LEAF_BITS'($urandom);                 // anywhere, reversed too
      2:       last = LEAF_BITS'($urandom_range(0, n - 1));
      default: begin                                        // forward span, mostly short
        span = $urandom_range(0, 3) == 0 ? n : 16;
        last = LEAF_BITS'((first + $urandom_range(0, span)) > 1023 ?
                          1023 : (first + $urandom_range(0, span)));
      end
    endcase
    send_item($urandom_range(0, 1) ? OP_QUERY : OP_WRITE, first, last, pick_value());
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Full tree: empty store, extreme values, extreme and reversed ranges.
  task automatic test_full_tree_extremes();
    set_leaf_count(11'd1024);
    send_item(OP_QUERY, 10'd0, 10'd1023, 31'h7FFF_FFFF);  // cleared store answers 0
    send_item(OP_WRITE, 10'd0, 10'd1023, 31'h7FFF_FFFF);
    send_item(OP_WRITE, 10'd1023, 10'd0, 31'd0);
    send_item(OP_WRITE, 10'd512, 10'h2AA, 31'd1);
    send_item(OP_WRITE, 10'd1022, 10'h155, 31'h5555_5555);
    send_item(OP_QUERY, 10'd0, 10'd1023, 31'd0);
    send_item(OP_QUERY, 10'd1, 10'd1023, 31'h2AAA_AAAA);
    send_item(OP_QUERY, 10'd1023, 10'd1023, 31'd0);
    send_item(OP_QUERY, 10'd512, 10'd512, 31'd0);
    send_item(OP_QUERY, 10'd1023, 10'd0, 31'd0);          // reversed range
    send_item(OP_QUERY, 10'd0, 10'd0, 31'd0);
  endtask

  // Small and odd leaf counts, zero and oversized counts, out-of-range fields.
  task automatic test_leaf_count_corners();
    set_leaf_count(11'd0);                                // acts as one leaf
    send_item(OP_WRITE, 10'd0, 10'd0, 31'd77);
    send_item(OP_WRITE, 10'd1, 10'd0, 31'd99);            // past the last leaf
    send_item(OP_QUERY, 10'd0, 10'd1023, 31'd0);          // end clips to last leaf
    send_item(OP_QUERY, 10'd1, 10'd1, 31'd0);             // start past the leaves
    set_leaf_count(11'd3);
    send_item(OP_WRITE, 10'd2, 10'd0, 31'd500);
    send_item(OP_WRITE, 10'd1, 10'd0, 31'd300);
    send_item(OP_QUERY, 10'd0, 10'd1, 31'd0);
    send_item(OP_QUERY, 10'd1, 10'd1023, 31'd0);
    set_leaf_count(11'd2047);                             // clips to 1024 leaves
    send_item(OP_QUERY, 10'd0, 10'd1023, 31'd0);          // store kept, offset changes
    send_item(OP_WRITE, 10'd1023, 10'd0, 31'd12);
    send_item(OP_QUERY, 10'd1000, 10'd1023, 31'd0);
  endtask

  // Random mix across leaf counts; one phase runs with no idling at all.
  task automatic test_random_mix();
    logic [CFG_BITS-1:0] counts [12];
    counts = '{11'd1024, 11'd1, 11'd2, 11'd7, 11'd100, 11'd1500,
               11'd1023, 11'd513, 11'd0, 11'd2047, 11'd64, 11'd333};
    foreach (counts[p]) begin
      set_leaf_count(counts[p]);
      steady_mode = (p == 4);
      repeat (150) send_random_item();
    end
    set_leaf_count(CFG_BITS'($urandom_range(1, 1024)));
    steady_mode = 1'b0;
    repeat (100) send_random_item();
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    foreach (shadow_tree[k]) shadow_tree[k] = '0;
    shadow_leaf_count = 11'd1024;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_full_tree_extremes();
    test_leaf_count_corners();
    test_random_mix();

    // Drain: everything owed, then room for the last write to finish.
    wait_idle();
    if (pending_max.size() != 0) begin
      report_mismatch("query answers never returned", VALUE_BITS'(pending_max.size()), '0);
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/rmst_pkg.sv
rtl/core/rmst_ram.sv
rtl/core/range_max_segment_tree.sv
tb/sv/tb_range_max_segment_tree.sv
